// ===== src/uts_pkg.sv =====
package uts_pkg;

  localparam int unsigned MAX_UNITS = 65535;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [31:0] QUESTION_MARK = 32'h0000_003F;
  localparam logic [31:0] CHAR_MAX      = 32'h0000_00FF;

  typedef enum logic [1:0] {
    ENC_UTF8    = 2'd0,
    ENC_UTF16LE = 2'd1,
    ENC_UTF32LE = 2'd2,
    ENC_NONE    = 2'd3
  } src_enc_e;

  typedef enum logic [1:0] {
    TGT_CHAR  = 2'd0,
    TGT_UTF16 = 2'd1,
    TGT_UTF32 = 2'd2,
    TGT_NONE  = 2'd3
  } tgt_width_e;

  typedef enum logic [0:0] {
    REG_SOURCE_ENCODING = 1'b0,
    REG_TARGET_WIDTH    = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUNC_DATA  = 1'b0,
    FUNC_START = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [15:0] request_units;
  } uts_in_t;

  typedef struct packed {
    logic [31:0] code_unit;
    logic        last_of_run;
    logic        budget_spent;
  } uts_out_t;

  typedef struct packed {
    logic [1:0]         count;
    uts_out_t [1:0]     unit;
  } uts_push_t;

  function automatic logic [2:0] utf8_trail(input logic [7:0] b);
    logic [2:0] t;
    begin
      if (b < 8'hC0)      t = 3'd0;
      else if (b < 8'hE0) t = 3'd1;
      else if (b < 8'hF0) t = 3'd2;
      else if (b < 8'hF8) t = 3'd3;
      else if (b < 8'hFC) t = 3'd4;
      else                t = 3'd5;
      return t;
    end
  endfunction

  function automatic logic [31:0] utf8_offset(input logic [2:0] trail);
    logic [31:0] o;
    begin
      case (trail)
        3'd0:    o = 32'h0000_0000;
        3'd1:    o = 32'h0000_3080;
        3'd2:    o = 32'h000E_2080;
        3'd3:    o = 32'h03C8_2080;
        3'd4:    o = 32'hFA08_2080;
        default: o = 32'h8208_2080;
      endcase
      return o;
    end
  endfunction

  function automatic logic is_high_surrogate(input logic [15:0] c);
    return c[15:10] == 6'b110110;
  endfunction

endpackage

// ===== src/utf_stream_transcoder.sv =====
// UTF stream transcoder.
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per byte of
// the encoded file, or a start transaction that loads the output unit budget.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transaction per code
// unit; a byte yields zero, one or two units, the last flagged last_of_run.
// Configuration channel (cfg_valid_i/cfg_ready_o): always ready; index 0 sets
// the source encoding, index 1 the target width. Write only while idle; a
// write drops any partial character but keeps the budget.
// A unit is offered once the byte that completes it has passed the input
// register and been decoded into a four-entry output queue; a full queue holds it back.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the queue has room; the single output port sends a surrogate pair unit by unit.
// Reset: source UTF-8, target UTF-32, budget zero, queue empty.
// When the receiver stalls the queue fills; decoding halts once fewer than two
// free entries remain and in_ready_o drops while a byte waits; no unit is lost.
module utf_stream_transcoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uts_pkg::uts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uts_pkg::uts_out_t out_data_o
);
  import uts_pkg::*;

  uts_push_t push;
  logic      room;

  assign cfg_ready_o = 1'b1;

  uts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .room_i      (room),
    .push_o      (push)
  );

  uts_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/uts_core.sv =====
module uts_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uts_pkg::uts_in_t  in_data_i,
  input  logic              room_i,
  output uts_pkg::uts_push_t push_o
);
  import uts_pkg::*;

  logic        in_vld_q;
  uts_in_t     in_q;
  logic        proc;

  src_enc_e    enc_q, enc_d;
  tgt_width_e  tgt_q, tgt_d;
  logic [15:0] ul_q, ul_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  pend_q, pend_d;
  logic [2:0]  trail_q, trail_d;
  logic [15:0] shs_q, shs_d;
  logic        sw_q, sw_d;

  assign proc       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q   <= ENC_UTF8;
      tgt_q   <= TGT_UTF32;
      ul_q    <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
      trail_q <= '0;
      shs_q   <= '0;
      sw_q    <= 1'b0;
    end else begin
      enc_q   <= enc_d;
      tgt_q   <= tgt_d;
      ul_q    <= ul_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      trail_q <= trail_d;
      shs_q   <= shs_d;
      sw_q    <= sw_d;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [31:0] acc_n;
    logic [31:0] cp;
    logic [31:0] w;
    logic [2:0]  pend_n;
    logic [2:0]  trail_n;
    logic        drop_unit;
    logic [1:0]  n;
    logic [31:0] u0;
    logic [31:0] u1;

    b         = in_q.data_byte;
    acc_n     = '0;
    cp        = '0;
    w         = '0;
    pend_n    = '0;
    trail_n   = '0;
    drop_unit = 1'b0;
    n         = 2'd0;
    u0        = '0;
    u1        = '0;

    enc_d   = enc_q;
    tgt_d   = tgt_q;
    ul_d    = ul_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    trail_d = trail_q;
    shs_d   = shs_q;
    sw_d    = sw_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SOURCE_ENCODING: enc_d = src_enc_e'(cfg_data_i);
        REG_TARGET_WIDTH:    tgt_d = tgt_width_e'(cfg_data_i);
        default:             enc_d = enc_q;
      endcase
      acc_d   = '0;
      pend_d  = '0;
      trail_d = '0;
      shs_d   = '0;
      sw_d    = 1'b0;
    end else if (proc) begin
      if (in_q.func == FUNC_START) begin
        ul_d    = (in_q.request_units < MAX_UNITS) ? in_q.request_units : 16'(MAX_UNITS);
        acc_d   = '0;
        pend_d  = '0;
        trail_d = '0;
        shs_d   = '0;
        sw_d    = 1'b0;
      end else if (ul_q != 16'd0 && enc_q != ENC_NONE && tgt_q != TGT_NONE) begin
        case (enc_q)
          ENC_UTF8: begin
            if (pend_q == 3'd0) begin
              trail_n = utf8_trail(b);
              acc_n   = {24'd0, b};
              pend_n  = trail_n;
            end else begin
              trail_n = trail_q;
              acc_n   = (acc_q << 6) + {24'd0, b};
              pend_n  = pend_q - 3'd1;
            end
            if (pend_n != 3'd0) begin
              acc_d   = acc_n;
              pend_d  = pend_n;
              trail_d = trail_n;
            end else begin
              cp      = acc_n - utf8_offset(trail_n);
              acc_d   = '0;
              pend_d  = '0;
              trail_d = '0;
              case (tgt_q)
                TGT_CHAR: begin
                  n  = 2'd1;
                  u0 = (cp > CHAR_MAX) ? QUESTION_MARK : cp;
                end
                TGT_UTF16: begin
                  w = cp - 32'h0001_0000;
                  if (cp <= 32'h0000_FFFF) begin
                    n  = 2'd1;
                    u0 = cp;
                  end else if (ul_q > 16'd1) begin
                    n  = 2'd2;
                    u0 = {16'd0, w[25:10] + 16'hD800};
                    u1 = {22'd0, w[9:0]} + 32'h0000_DC00;
                  end else begin
                    drop_unit = 1'b1;
                  end
                end
                default: begin
                  n  = 2'd1;
                  u0 = cp;
                end
              endcase
            end
          end
          ENC_UTF16LE: begin
            acc_n  = acc_q | ({24'd0, b} << {pend_q[0], 3'b000});
            pend_n = pend_q + 3'd1;
            if (pend_n < 3'd2) begin
              acc_d  = acc_n;
              pend_d = pend_n;
            end else begin
              cp     = {16'd0, acc_n[15:0]};
              acc_d  = '0;
              pend_d = '0;
              case (tgt_q)
                TGT_UTF16: begin
                  n  = 2'd1;
                  u0 = cp;
                end
                TGT_CHAR: begin
                  if (sw_q) begin
                    sw_d = 1'b0;
                    n    = 2'd1;
                    u0   = QUESTION_MARK;
                  end else if (cp > CHAR_MAX) begin
                    if (is_high_surrogate(cp[15:0])) begin
                      sw_d = 1'b1;
                    end else begin
                      n  = 2'd1;
                      u0 = QUESTION_MARK;
                    end
                  end else begin
                    n  = 2'd1;
                    u0 = cp;
                  end
                end
                default: begin
                  if (sw_q) begin
                    sw_d = 1'b0;
                    w    = (({16'd0, shs_q} - 32'h0000_D800) << 10)
                         + (cp - 32'h0000_DC00) + 32'h0001_0000;
                    n    = 2'd1;
                    u0   = w;
                  end else if (is_high_surrogate(cp[15:0])) begin
                    shs_d = cp[15:0];
                    sw_d  = 1'b1;
                  end else begin
                    n  = 2'd1;
                    u0 = cp;
                  end
                end
              endcase
            end
          end
          default: begin
            acc_n  = acc_q | ({24'd0, b} << {pend_q[1:0], 3'b000});
            pend_n = pend_q + 3'd1;
            if (pend_n < 3'd4) begin
              acc_d  = acc_n;
              pend_d = pend_n;
            end else begin
              cp     = acc_n;
              acc_d  = '0;
              pend_d = '0;
              case (tgt_q)
                TGT_CHAR: begin
                  n  = 2'd1;
                  u0 = (cp > CHAR_MAX) ? QUESTION_MARK : cp;
                end
                TGT_UTF16: begin
                  w = cp - 32'h0001_0000;
                  if (cp > 32'h0000_FFFF) begin
                    if (ul_q > 16'd1) begin
                      n  = 2'd2;
                      u0 = {16'd0, w[25:10] + 16'hD800};
                      u1 = {22'd0, w[9:0]} + 32'h0000_DC00;
                    end else begin
                      n  = 2'd1;
                      u0 = {22'd0, w[9:0]} + 32'h0000_DC00;
                    end
                  end else begin
                    n  = 2'd1;
                    u0 = cp;
                  end
                end
                default: begin
                  n  = 2'd1;
                  u0 = cp;
                end
              endcase
            end
          end
        endcase
        ul_d = drop_unit ? (ul_q - 16'd1) : (ul_q - {14'd0, n});
      end
    end

    push_o.count                  = n;
    push_o.unit[0].code_unit      = u0;
    push_o.unit[0].last_of_run    = (n == 2'd1);
    push_o.unit[0].budget_spent   = (ul_q == 16'd1);
    push_o.unit[1].code_unit      = u1;
    push_o.unit[1].last_of_run    = 1'b1;
    push_o.unit[1].budget_spent   = (ul_q == 16'd2);
  end

endmodule

// ===== src/uts_out_fifo.sv =====
module uts_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uts_pkg::uts_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output uts_pkg::uts_out_t  out_data_o
);
  import uts_pkg::*;

  uts_out_t             mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0] wr_ptr_nx;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign wr_ptr_nx   = wr_ptr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CNT_W'(push_i.count) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.unit[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.unit[1];
    end
  end

endmodule

// ===== verif/utf_stream_checker.sv =====
`timescale 1ns / 1ps
module utf_stream_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [1:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  uts_pkg::uts_in_t  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  uts_pkg::uts_out_t out_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import uts_pkg::*;

  localparam logic [31:0] QMARK      = 32'h0000_003F;
  localparam logic [31:0] CHAR_LIMIT = 32'h0000_00FF;
  localparam logic [31:0] UTF8_BIAS [6] = '{
    32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
    32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
  };

  src_enc_e    src_enc;
  tgt_width_e  tgt_width;
  logic [15:0] units_left;
  logic [31:0] acc;
  logic [2:0]  bytes_pend;
  logic [2:0]  trail_len;
  logic [15:0] high_half;
  logic        pair_open;

  uts_out_t    run_buf [2];
  int          run_len;
  uts_out_t    expected_units [$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 100) $display("%0t: transcoder mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [2:0] seq_trail(input logic [7:0] b);
    if (b < 8'hC0) return 3'd0;
    if (b < 8'hE0) return 3'd1;
    if (b < 8'hF0) return 3'd2;
    if (b < 8'hF8) return 3'd3;
    if (b < 8'hFC) return 3'd4;
    return 3'd5;
  endfunction

  function automatic void drop_partial();
    acc        = '0;
    bytes_pend = '0;
    trail_len  = '0;
    high_half  = '0;
    pair_open  = 1'b0;
  endfunction

  // every unit spends one unit of budget, the flag shows the budget after it
  function automatic void put_unit(input logic [31:0] u);
    if (units_left != 0) units_left = units_left - 1'b1;
    run_buf[run_len].code_unit    = u;
    run_buf[run_len].last_of_run  = 1'b0;
    run_buf[run_len].budget_spent = (units_left == 0);
    run_len++;
  endfunction

  function automatic void put_pair(input logic [31:0] c, input logic want_high);
    logic [31:0] w;
    w = c - 32'h0001_0000;
    if (want_high) put_unit(((w >> 10) + 32'h0000_D800) & 32'h0000_FFFF);
    put_unit((w & 32'h0000_03FF) + 32'h0000_DC00);
  endfunction

  task automatic transcode_item(input uts_in_t item);
    logic [31:0] b;
    logic [31:0] c;
    run_len = 0;
    b = {24'd0, item.data_byte};
    if (item.func == FUNC_START) begin
      units_left = item.request_units;
      drop_partial();
      return;
    end
    if (units_left == 0 || src_enc == ENC_NONE || tgt_width == TGT_NONE) return;
    case (src_enc)
      ENC_UTF8: begin
        if (bytes_pend == 0) begin
          trail_len  = seq_trail(item.data_byte);
          acc        = b;
          bytes_pend = trail_len;
        end else begin
          acc        = (acc << 6) + b;
          bytes_pend = bytes_pend - 1'b1;
        end
        if (bytes_pend == 0) begin
          c = acc - UTF8_BIAS[trail_len];
          acc = '0;
          trail_len = '0;
          case (tgt_width)
            TGT_CHAR: put_unit((c > CHAR_LIMIT) ? QMARK : c);
            TGT_UTF16: begin
              if (c <= 32'h0000_FFFF) put_unit(c);
              else if (units_left > 1) put_pair(c, 1'b1);
              else units_left = units_left - 1'b1;
            end
            default: put_unit(c);
          endcase
        end
      end
      ENC_UTF16LE: begin
        acc = acc | (b << (bytes_pend[0] ? 8 : 0));
        bytes_pend = bytes_pend + 1'b1;
        if (bytes_pend == 3'd2) begin
          c = acc & 32'h0000_FFFF;
          acc = '0;
          bytes_pend = '0;
          case (tgt_width)
            TGT_UTF16: put_unit(c);
            TGT_CHAR: begin
              if (pair_open) begin
                pair_open = 1'b0;
                put_unit(QMARK);
              end else if (c > CHAR_LIMIT) begin
                if (c >= 32'h0000_D800 && c <= 32'h0000_DBFF) pair_open = 1'b1;
                else put_unit(QMARK);
              end else begin
                put_unit(c);
              end
            end
            default: begin
              if (pair_open) begin
                pair_open = 1'b0;
                put_unit((({16'd0, high_half} - 32'h0000_D800) << 10)
                         + (c - 32'h0000_DC00) + 32'h0001_0000);
              end else if (c >= 32'h0000_D800 && c <= 32'h0000_DBFF) begin
                high_half = c[15:0];
                pair_open = 1'b1;
              end else begin
                put_unit(c);
              end
            end
          endcase
        end
      end
      default: begin
        acc = acc | (b << (8 * bytes_pend[1:0]));
        bytes_pend = bytes_pend + 1'b1;
        if (bytes_pend == 3'd4) begin
          c = acc;
          acc = '0;
          bytes_pend = '0;
          case (tgt_width)
            TGT_CHAR: put_unit((c > CHAR_LIMIT) ? QMARK : c);
            TGT_UTF16: begin
              if (c > 32'h0000_FFFF) put_pair(c, units_left > 1);
              else put_unit(c);
            end
            default: put_unit(c);
          endcase
        end
      end
    endcase
    if (run_len > 0) run_buf[run_len - 1].last_of_run = 1'b1;
    for (int i = 0; i < run_len; i++) expected_units.push_back(run_buf[i]);
  endtask

  task automatic compare_unit(input uts_out_t got);
    uts_out_t want;
    if (expected_units.size() == 0) begin
      report_mismatch($sformatf("unit %h with nothing expected", got.code_unit));
      return;
    end
    want = expected_units.pop_front();
    if (got.code_unit !== want.code_unit)
      report_mismatch($sformatf("code_unit %h, expected %h", got.code_unit, want.code_unit));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run %b, expected %b on unit %h",
                                got.last_of_run, want.last_of_run, want.code_unit));
    if (got.budget_spent !== want.budget_spent)
      report_mismatch($sformatf("budget_spent %b, expected %b on unit %h",
                                got.budget_spent, want.budget_spent, want.code_unit));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_enc    = ENC_UTF8;
      tgt_width  = TGT_UTF32;
      units_left = '0;
      drop_partial();
      expected_units.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_SOURCE_ENCODING) src_enc = src_enc_e'(cfg_data_i);
        else tgt_width = tgt_width_e'(cfg_data_i);
        drop_partial();
      end
      if (in_valid_i && in_ready_i) transcode_item(in_data_i);
      if (out_valid_i && out_ready_i) compare_unit(out_data_i);
      pending_o <= expected_units.size();
    end
  end

endmodule

// ===== verif/utf_stream_transcoder_test.sv =====
`timescale 1ns / 1ps
module utf_stream_transcoder_test;
  import uts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LIVE_TARGET = 1250;
  localparam logic [7:0]  LEAD_MARK [6] = '{8'h00, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = REG_SOURCE_ENCODING;
  logic [1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  uts_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  uts_out_t   out_data;
  int         fail_count;
  int         pending;

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned live_items = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned phase_no = 0;

  utf_stream_transcoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  utf_stream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[utf_stream_transcoder] ERROR");
      $finish;
    end
  end

  // receiver: free-running, random, or long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if ($urandom_range(0, 11) == 0) out_ready <= ~out_ready;
      end
    endcase
  end

  task automatic send_item(input uts_in_t item);
    live_items++;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(50, 200);
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b);
    uts_in_t item;
    item.func          = FUNC_DATA;
    item.data_byte     = b;
    item.request_units = 16'($urandom_range(0, 16'hFFFF));
    send_item(item);
  endtask

  task automatic send_start(input logic [15:0] budget);
    uts_in_t item;
    item.func          = FUNC_START;
    item.data_byte     = 8'($urandom_range(0, 255));
    item.request_units = budget;
    send_item(item);
  endtask

  task automatic send_char(input src_enc_e enc, input logic [31:0] cp, input logic broken);
    logic [7:0]  seq [$];
    logic [31:0] w;
    logic [15:0] hi;
    logic [15:0] lo;
    int          n;
    case (enc)
      ENC_UTF8: begin
        if (cp < 32'h80) n = 0;
        else if (cp < 32'h800) n = 1;
        else if (cp < 32'h1_0000) n = 2;
        else if (cp < 32'h20_0000) n = 3;
        else if (cp < 32'h400_0000) n = 4;
        else n = 5;
        w = cp >> (6 * n);
        seq.push_back(LEAD_MARK[n] | w[7:0]);
        for (int i = n - 1; i >= 0; i--) begin
          w = cp >> (6 * i);
          seq.push_back(8'h80 | {2'b00, w[5:0]});
        end
      end
      ENC_UTF16LE: begin
        if (cp >= 32'h1_0000 && cp <= 32'h10_FFFF) begin
          w  = cp - 32'h1_0000;
          hi = 16'hD800 + {6'd0, w[19:10]};
          lo = 16'hDC00 + {6'd0, w[9:0]};
          seq.push_back(hi[7:0]);
          seq.push_back(hi[15:8]);
          seq.push_back(lo[7:0]);
          seq.push_back(lo[15:8]);
        end else begin
          seq.push_back(cp[7:0]);
          seq.push_back(cp[15:8]);
        end
      end
      default: begin
        seq.push_back(cp[7:0]);
        seq.push_back(cp[15:8]);
        seq.push_back(cp[23:16]);
        seq.push_back(cp[31:24]);
      end
    endcase
    if (broken && seq.size() > 1) void'(seq.pop_back());
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 32'h7F);
    if (r < 45) return $urandom_range(32'h80, 32'h7FF);
    if (r < 60) return $urandom_range(32'h800, 32'hFFFF);
    if (r < 70) return $urandom_range(32'hD800, 32'hDFFF);
    if (r < 90) return $urandom_range(32'h1_0000, 32'h10_FFFF);
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_budget();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 22) return 16'($urandom_range(1, 3));
    if (r < 28) return 16'($urandom_range(0, 16'hFFFF));
    return 16'($urandom_range(4, 100));
  endfunction

  task automatic run_directed();
    // reset state: UTF-8 in, UTF-32 out, no budget
    send_byte(8'h41);
    send_start(16'hFFFF);
    send_byte(8'hFF);
    repeat (5) send_byte(8'hBF);
    settle();
    write_reg(REG_TARGET_WIDTH, TGT_UTF16);
    send_start(16'd1);
    send_char(ENC_UTF8, 32'h1_F600, 1'b0);
    send_start(16'd2);
    send_char(ENC_UTF8, 32'h1_F600, 1'b0);
    settle();
    write_reg(REG_SOURCE_ENCODING, ENC_UTF16LE);
    write_reg(REG_TARGET_WIDTH, TGT_CHAR);
    send_start(16'd4);
    send_char(ENC_UTF16LE, 32'h1_F600, 1'b0);
    send_char(ENC_UTF16LE, 32'h20AC, 1'b0);
    settle();
    write_reg(REG_SOURCE_ENCODING, ENC_UTF32LE);
    write_reg(REG_TARGET_WIDTH, TGT_UTF16);
    send_start(16'd1);
    send_char(ENC_UTF32LE, 32'h1_F600, 1'b0);
  endtask

  task automatic random_phase(input int unsigned idx);
    src_enc_e    src;
    tgt_width_e  tgt;
    int unsigned r;
    int unsigned nchars;
    if (idx < 16) begin
      src = src_enc_e'(idx % 4);
      tgt = tgt_width_e'(idx / 4);
    end else begin
      src = ($urandom_range(0, 19) == 0) ? ENC_NONE : src_enc_e'($urandom_range(0, 2));
      tgt = ($urandom_range(0, 19) == 0) ? TGT_NONE : tgt_width_e'($urandom_range(0, 2));
    end
    settle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_SOURCE_ENCODING, src);
      write_reg(REG_TARGET_WIDTH, tgt);
    end else begin
      write_reg(REG_TARGET_WIDTH, tgt);
      write_reg(REG_SOURCE_ENCODING, src);
    end
    // sometimes keep the budget left over from the previous phase
    if ($urandom_range(0, 9) != 0) send_start(pick_budget());
    nchars = $urandom_range(4, 40);
    repeat (nchars) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_start(pick_budget());
      else if (r < 12) send_byte(8'($urandom_range(0, 255)));
      else send_char(src, pick_code(), $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (live_items < LIVE_TARGET) begin
      random_phase(phase_no);
      phase_no++;
    end
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[utf_stream_transcoder] OK");
    end else begin
      $display("[utf_stream_transcoder] ERROR");
    end
    $finish;
  end

endmodule
